FILE: rtl/core/xnor_popcount_conv_threshold_assert.svh
// Assertion macros for the xnor popcount convolution block.
// Included by the top level; define NO_ASSERTIONS to compile them out.
`ifndef XNOR_POPCOUNT_CONV_THRESHOLD_ASSERT_SVH
`define XNOR_POPCOUNT_CONV_THRESHOLD_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define XPC_ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("xpc assertion failed");
// next-cycle implication, checked out of reset
`define XPC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("xpc assertion failed");
`else
`define XPC_ASSERT_IMPL(label, clk, rst_n, cond, expr)
`define XPC_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

FILE: rtl/core/xpc_pkg.sv
// Shared types, constants and the popcount function for the xnor popcount
// convolution block. No dependencies.
`default_nettype none

package xpc_pkg;

    localparam int WORD_BITS = 32;
    localparam int SUM_W     = 18;
    localparam int THR_W     = 16;
    localparam int CNT_W     = $clog2(WORD_BITS + 1);
    // signed agree-minus-zeros difference, then one more bit for the plane shift
    localparam int TERM_W    = CNT_W + 2;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int IDX_W     = 3;

    localparam logic [WORD_BITS-1:0] M1 = 32'h5555_5555;
    localparam logic [WORD_BITS-1:0] M2 = 32'h3333_3333;
    localparam logic [WORD_BITS-1:0] M4 = 32'h0F0F_0F0F;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOW      = 3'd1;
    localparam logic [IDX_W-1:0] REG_MID      = 3'd2;
    localparam logic [IDX_W-1:0] REG_HIGH     = 3'd3;
    localparam logic [IDX_W-1:0] REG_MODE     = 3'd4;
    localparam logic [IDX_W-1:0] REG_CONSTANT = 3'd5;

    // threshold modes; anything else is constant mode
    localparam logic [1:0] MODE_INC = 2'd0;
    localparam logic [1:0] MODE_DEC = 2'd1;

    typedef logic [CNT_W-1:0]         count_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        term_t term;
        logic  last;
    } entry_t;

    typedef struct packed {
        logic                    enable;
        logic signed [THR_W-1:0] low;
        logic signed [THR_W-1:0] mid;
        logic signed [THR_W-1:0] high;
        logic [1:0]              mode;
        logic [1:0]              level;
    } cfg_t;

    function automatic count_t popcount(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] s1;
        logic [WORD_BITS-1:0] s2;
        logic [WORD_BITS-1:0] s4;
        logic [7:0]           bsum;
        s1   = v - ((v >> 1) & M1);
        s2   = (s1 & M2) + ((s1 >> 2) & M2);
        s4   = (s2 + (s2 >> 4)) & M4;
        bsum = s4[7:0] + s4[15:8] + s4[23:16] + s4[31:24];
        return bsum[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/xpc_front.sv
// Front stage: accepts input items, forms the signed popcount term per word.
// Depends on xpc_pkg.
`default_nettype none

module xpc_front
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [xpc_pkg::WORD_BITS-1:0]  activation_word,
    input  wire logic [xpc_pkg::WORD_BITS-1:0]  weight_word,
    input  wire logic                           plane_index,
    input  wire logic                           last,
    output logic                                push_valid,
    output xpc_pkg::entry_t                     push_entry,
    input  wire logic                           q_full
);

    logic                      f_valid_reg;
    logic                      f_valid_next;
    xpc_pkg::entry_t           f_entry_reg;
    xpc_pkg::count_t           agree;
    xpc_pkg::count_t           zeros;
    logic signed [xpc_pkg::CNT_W:0] diff;
    xpc_pkg::term_t            term;
    logic                      take;

    assign agree = xpc_pkg::popcount(~(activation_word ^ weight_word));
    assign zeros = xpc_pkg::popcount(~weight_word);
    assign diff  = $signed({1'b0, agree}) - $signed({1'b0, zeros});
    assign term  = plane_index ? {diff, 1'b0} : {diff[xpc_pkg::CNT_W], diff};

    // stage holds only while the queue is full
    assign in_stall = f_valid_reg && q_full;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (take)
        begin
            f_valid_next = 1'b1;
        end
        else if (f_valid_reg && !q_full)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_entry_reg.term <= term;
            f_entry_reg.last <= last;
        end
    end

    assign push_valid = f_valid_reg;
    assign push_entry = f_entry_reg;

endmodule

`default_nettype wire

FILE: rtl/core/xpc_queue.sv
// Short FIFO of terms between the front and back stages.
// Depends on xpc_pkg.
`default_nettype none

module xpc_queue
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push_valid,
    input  wire xpc_pkg::entry_t             push_entry,
    output logic                             q_full,
    input  wire logic                        pop,
    output logic                             q_valid,
    output xpc_pkg::entry_t                  head,
    output logic [xpc_pkg::Q_CNT_W-1:0]      q_count
);

    xpc_pkg::entry_t                   mem [xpc_pkg::Q_DEPTH];
    logic [xpc_pkg::Q_PTR_W-1:0]       wr_ptr_reg;
    logic [xpc_pkg::Q_PTR_W-1:0]       rd_ptr_reg;
    logic [xpc_pkg::Q_CNT_W-1:0]       count_reg;
    logic [xpc_pkg::Q_CNT_W-1:0]       count_next;
    logic                              do_push;
    logic                              do_pop;

    assign q_full  = count_reg == xpc_pkg::Q_CNT_W'(xpc_pkg::Q_DEPTH);
    assign q_valid = count_reg != '0;
    assign do_push = push_valid && !q_full;
    assign do_pop  = pop && q_valid;
    assign head    = mem[rd_ptr_reg];
    assign q_count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/xpc_back.sv
// Back stage: accumulates terms, applies thresholds on the last item of a
// patch and holds the result in an output register. Depends on xpc_pkg.
`default_nettype none

module xpc_back
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire xpc_pkg::cfg_t               cfg,
    input  wire logic                        q_valid,
    input  wire xpc_pkg::entry_t             head,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [xpc_pkg::SUM_W-1:0] channel_value
);

    xpc_pkg::sum_t  sum_reg;
    xpc_pkg::sum_t  sum_next;
    xpc_pkg::sum_t  acc;
    xpc_pkg::sum_t  lo;
    xpc_pkg::sum_t  mi;
    xpc_pkg::sum_t  hi;
    xpc_pkg::sum_t  result;
    xpc_pkg::sum_t  value_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           slot_free;
    logic           load;

    localparam int EXT_W = xpc_pkg::SUM_W - xpc_pkg::TERM_W;
    localparam int THR_EXT_W = xpc_pkg::SUM_W - xpc_pkg::THR_W;

    assign slot_free = !out_valid_reg || !out_stall;
    // a last item waits until the output register can take its result
    assign pop  = q_valid && (!head.last || slot_free);
    assign load = pop && head.last;

    assign acc = sum_reg + {{EXT_W{head.term[xpc_pkg::TERM_W-1]}}, head.term};
    assign lo  = {{THR_EXT_W{cfg.low[xpc_pkg::THR_W-1]}}, cfg.low};
    assign mi  = {{THR_EXT_W{cfg.mid[xpc_pkg::THR_W-1]}}, cfg.mid};
    assign hi  = {{THR_EXT_W{cfg.high[xpc_pkg::THR_W-1]}}, cfg.high};

    always_comb
    begin
        result = acc;
        if (cfg.enable)
        begin
            case (cfg.mode)
                xpc_pkg::MODE_INC:
                begin
                    if (acc < lo)      result = xpc_pkg::SUM_W'(0);
                    else if (acc < mi) result = xpc_pkg::SUM_W'(1);
                    else if (acc < hi) result = xpc_pkg::SUM_W'(2);
                    else               result = xpc_pkg::SUM_W'(3);
                end
                xpc_pkg::MODE_DEC:
                begin
                    if (acc > hi)      result = xpc_pkg::SUM_W'(0);
                    else if (acc > mi) result = xpc_pkg::SUM_W'(1);
                    else if (acc > lo) result = xpc_pkg::SUM_W'(2);
                    else               result = xpc_pkg::SUM_W'(3);
                end
                default:
                begin
                    result = {{(xpc_pkg::SUM_W-2){1'b0}}, cfg.level};
                end
            endcase
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (pop)
        begin
            sum_next = head.last ? '0 : acc;
        end
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel_value = value_reg;

endmodule

`default_nettype wire

FILE: rtl/core/xnor_popcount_conv_threshold.sv
// Top level of the xnor popcount convolution channel with threshold output.
// Depends on xpc_pkg, xpc_front, xpc_queue, xpc_back and the assertion header.
`default_nettype none

// One output channel of a binary-weight convolution. Each input item is one
// 32-bit activation bit-plane word with its weight word; the block adds
// (popcount(xnor) - zero count of weights) << plane_index to an 18-bit sum,
// and on an item with last set delivers the raw sum or a 2-bit threshold
// level, then clears the sum. One item per clock is sustained while the
// output does not stall: the front stage registers the popcount term, a
// 4-entry queue decouples it from the back stage, which accumulates one
// term per cycle. Output stalls back up through the queue; the input stalls
// only once the queue is full. Configuration is to be written with
// wr_en/wr_index/wr_data while idle; the block does not enforce it.
module xnor_popcount_conv_threshold
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [xpc_pkg::WORD_BITS-1:0]  activation_word,
    input  wire logic [xpc_pkg::WORD_BITS-1:0]  weight_word,
    input  wire logic                           plane_index,
    input  wire logic                           last,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [xpc_pkg::SUM_W-1:0]    channel_value,
    input  wire logic                           wr_en,
    input  wire logic [xpc_pkg::IDX_W-1:0]      wr_index,
    input  wire logic [xpc_pkg::THR_W-1:0]      wr_data
);

`include "xnor_popcount_conv_threshold_assert.svh"

    xpc_pkg::cfg_t                   cfg_reg;
    logic                            push_valid;
    xpc_pkg::entry_t                 push_entry;
    logic                            q_full;
    logic                            q_valid;
    logic                            pop;
    xpc_pkg::entry_t                 head;
    logic [xpc_pkg::Q_CNT_W-1:0]     q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                xpc_pkg::REG_ENABLE:   cfg_reg.enable <= wr_data[0];
                xpc_pkg::REG_LOW:      cfg_reg.low    <= wr_data;
                xpc_pkg::REG_MID:      cfg_reg.mid    <= wr_data;
                xpc_pkg::REG_HIGH:     cfg_reg.high   <= wr_data;
                xpc_pkg::REG_MODE:     cfg_reg.mode   <= wr_data[1:0];
                xpc_pkg::REG_CONSTANT: cfg_reg.level  <= wr_data[1:0];
                default:               cfg_reg        <= cfg_reg;
            endcase
        end
    end

    xpc_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .activation_word (activation_word),
        .weight_word     (weight_word),
        .plane_index     (plane_index),
        .last            (last),
        .push_valid      (push_valid),
        .push_entry      (push_entry),
        .q_full          (q_full)
    );

    xpc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .q_full     (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .head       (head),
        .q_count    (q_count)
    );

    xpc_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel_value (channel_value)
    );

    // the input only backs up when the front holds an item and the queue is full
    `XPC_ASSERT_IMPL(a_stall_needs_full, clk, rst_n, in_stall,
                     push_valid && q_count == xpc_pkg::Q_CNT_W'(xpc_pkg::Q_DEPTH))
    // a last item never leaves the queue while the output register is blocked
    `XPC_ASSERT_IMPL(a_no_lost_result, clk, rst_n, pop && head.last && out_valid,
                     !out_stall)
    // levels stay in two bits whenever thresholds are on
    `XPC_ASSERT_NEXT(a_level_range, clk, rst_n, pop && head.last && cfg_reg.enable,
                     channel_value[xpc_pkg::SUM_W-1:2] == '0)

endmodule

`default_nettype wire

FILE: tb/sv/xpc_channel_checker.sv
`timescale 1ns / 100ps
// Checker for the xnor popcount convolution channel: watches the item, result and
// register-write ports, predicts every channel value and compares it with the output.
// Depends on xpc_pkg for widths, register indexes, threshold modes and cfg_t.
module xpc_channel_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [xpc_pkg::WORD_BITS-1:0]       activation_word,
    input  logic [xpc_pkg::WORD_BITS-1:0]       weight_word,
    input  logic                                plane_index,
    input  logic                                last,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [xpc_pkg::SUM_W-1:0]    channel_value,
    input  logic                                wr_en,
    input  logic [xpc_pkg::IDX_W-1:0]           wr_index,
    input  logic [xpc_pkg::THR_W-1:0]           wr_data,
    output int                                  fail_count,
    output int                                  results_due
);

    xpc_pkg::sum_t patch_sum;
    xpc_pkg::cfg_t thresholds;
    xpc_pkg::sum_t channel_values_due[$];

    // agreements minus weight zeros, doubled on the upper bit plane
    function automatic xpc_pkg::sum_t word_term(input logic [xpc_pkg::WORD_BITS-1:0] act,
                                                input logic [xpc_pkg::WORD_BITS-1:0] wgt,
                                                input logic plane);
        int agree;
        int zeros;
        int diff;
        agree = 0;
        zeros = 0;
        for (int i = 0; i < xpc_pkg::WORD_BITS; i++)
        begin
            if (act[i] == wgt[i])
                agree++;
            if (!wgt[i])
                zeros++;
        end
        diff = agree - zeros;
        if (plane)
            diff = diff * 2;
        return xpc_pkg::SUM_W'(diff);
    endfunction

    function automatic xpc_pkg::sum_t channel_result(input xpc_pkg::sum_t sum,
                                                     input xpc_pkg::cfg_t c);
        int s;
        int lo;
        int mi;
        int hi;
        s  = int'(sum);
        lo = int'($signed(c.low));
        mi = int'($signed(c.mid));
        hi = int'($signed(c.high));
        if (!c.enable)
            return sum;
        if (c.mode == xpc_pkg::MODE_INC)
        begin
            if (s < lo)
                return xpc_pkg::SUM_W'(0);
            else if (s < mi)
                return xpc_pkg::SUM_W'(1);
            else if (s < hi)
                return xpc_pkg::SUM_W'(2);
            else
                return xpc_pkg::SUM_W'(3);
        end
        if (c.mode == xpc_pkg::MODE_DEC)
        begin
            if (s > hi)
                return xpc_pkg::SUM_W'(0);
            else if (s > mi)
                return xpc_pkg::SUM_W'(1);
            else if (s > lo)
                return xpc_pkg::SUM_W'(2);
            else
                return xpc_pkg::SUM_W'(3);
        end
        // constant mode, including the spare mode code
        return xpc_pkg::SUM_W'(c.level);
    endfunction

    always @(posedge clk)
    begin : track
        xpc_pkg::sum_t expected;
        if (!rst_n)
        begin
            patch_sum  = '0;
            thresholds = '0;
            fail_count = 0;
            channel_values_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (channel_values_due.size() == 0)
                begin
                    $error("channel_value %0d delivered with no patch outstanding",
                           channel_value);
                    fail_count++;
                end
                else
                begin
                    expected = channel_values_due.pop_front();
                    if (channel_value !== expected)
                    begin
                        $error("channel_value mismatch: expected %0d, actual %0d",
                               expected, channel_value);
                        fail_count++;
                    end
                end
            end

            if (wr_en)
            begin
                case (wr_index)
                    xpc_pkg::REG_ENABLE:   thresholds.enable = wr_data[0];
                    xpc_pkg::REG_LOW:      thresholds.low    = wr_data;
                    xpc_pkg::REG_MID:      thresholds.mid    = wr_data;
                    xpc_pkg::REG_HIGH:     thresholds.high   = wr_data;
                    xpc_pkg::REG_MODE:     thresholds.mode   = wr_data[1:0];
                    xpc_pkg::REG_CONSTANT: thresholds.level  = wr_data[1:0];
                    default:               ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                patch_sum = patch_sum + word_term(activation_word, weight_word, plane_index);
                if (last)
                begin
                    channel_values_due.push_back(channel_result(patch_sum, thresholds));
                    patch_sum = '0;
                end
            end
        end
        results_due = channel_values_due.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the xnor popcount convolution channel testbench: clock, reset, item and
// register stimulus, output stall control, watchdog and verdict.
// Depends on xpc_pkg, the block and xpc_channel_checker.
module tb_top;

    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 90;
    localparam int LONG_WORDS     = 600;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [xpc_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [xpc_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [1:0]                MODE_CONST   = 2'd2;
    localparam logic [1:0]                MODE_SPARE   = 2'd3;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic [xpc_pkg::WORD_BITS-1:0]        activation_word = '0;
    logic [xpc_pkg::WORD_BITS-1:0]        weight_word = '0;
    logic                                 plane_index = 1'b0;
    logic                                 last = 1'b0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [xpc_pkg::SUM_W-1:0]     channel_value;
    logic                                 wr_en = 1'b0;
    logic [xpc_pkg::IDX_W-1:0]            wr_index = '0;
    logic [xpc_pkg::THR_W-1:0]            wr_data = '0;

    int fail_count;
    int results_due;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit long_hold_req = 1'b0;
    int stalled_cycles = 0;
    int words_sent = 0;
    int patches_sent = 0;
    int configs_loaded = 0;

    xnor_popcount_conv_threshold u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .activation_word (activation_word),
        .weight_word     (weight_word),
        .plane_index     (plane_index),
        .last            (last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .channel_value   (channel_value),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data)
    );

    xpc_channel_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .activation_word (activation_word),
        .weight_word     (weight_word),
        .plane_index     (plane_index),
        .last            (last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .channel_value   (channel_value),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .fail_count      (fail_count),
        .results_due     (results_due)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // output side: random stalls, or one long hold-off when requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no item moved for %0d cycles, %0d results outstanding",
                   stalled_cycles, results_due);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // called just after a rising clock; returns once the block has taken the item
    task automatic send_word(input logic [xpc_pkg::WORD_BITS-1:0] act,
                             input logic [xpc_pkg::WORD_BITS-1:0] wgt,
                             input logic plane,
                             input logic end_of_patch);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid        <= 1'b0;
            activation_word <= $urandom();
            weight_word     <= $urandom();
            plane_index     <= 1'($urandom_range(0, 1));
            last            <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        activation_word <= act;
        weight_word     <= wgt;
        plane_index     <= plane;
        last            <= end_of_patch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (end_of_patch)
            patches_sent++;
    endtask

    // one single-word patch whose term is exactly t (plane 0)
    task automatic send_term(input int t);
        logic [xpc_pkg::WORD_BITS-1:0] ones_mask;
        int n;
        n = (t < 0) ? -t : t;
        ones_mask = '0;
        for (int i = 0; i < n; i++)
            ones_mask[i] = 1'b1;
        send_word(ones_mask, {xpc_pkg::WORD_BITS{t >= 0}}, 1'b0, 1'b1);
    endtask

    task automatic send_patch(input int len);
        logic [xpc_pkg::WORD_BITS-1:0] act;
        logic [xpc_pkg::WORD_BITS-1:0] wgt;
        for (int i = 0; i < len; i++)
        begin
            act = $urandom();
            wgt = $urandom();
            // bias some words toward large terms so sums spread past the thresholds
            case ($urandom_range(0, 5))
                0: act = wgt;
                1: act = ~wgt;
                2: wgt = '1;
                3: wgt = '0;
                default: ;
            endcase
            send_word(act, wgt, 1'($urandom_range(0, 1)), i == len - 1);
        end
    endtask

    // full write of every register, spare indexes included; unused data bits are junk
    task automatic load_config(input xpc_pkg::cfg_t c);
        wr_en    <= 1'b1;
        wr_index <= xpc_pkg::REG_ENABLE;
        wr_data  <= xpc_pkg::THR_W'(($urandom() & 32'hFFFE) | c.enable);
        @(posedge clk);
        wr_index <= xpc_pkg::REG_LOW;
        wr_data  <= c.low;
        @(posedge clk);
        wr_index <= xpc_pkg::REG_MID;
        wr_data  <= c.mid;
        @(posedge clk);
        wr_index <= xpc_pkg::REG_HIGH;
        wr_data  <= c.high;
        @(posedge clk);
        wr_index <= xpc_pkg::REG_MODE;
        wr_data  <= xpc_pkg::THR_W'(($urandom() & 32'hFFFC) | c.mode);
        @(posedge clk);
        wr_index <= xpc_pkg::REG_CONSTANT;
        wr_data  <= xpc_pkg::THR_W'(($urandom() & 32'hFFFC) | c.level);
        @(posedge clk);
        wr_index <= REG_SPARE_LO;
        wr_data  <= xpc_pkg::THR_W'($urandom());
        @(posedge clk);
        wr_index <= REG_SPARE_HI;
        wr_data  <= xpc_pkg::THR_W'($urandom());
        @(posedge clk);
        wr_en    <= 1'b0;
        configs_loaded++;
    endtask

    // stop offering items, wait for every result, then let trailing words clear
    task automatic settle_block();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        xpc_pkg::cfg_t cfg;
        int            words_in_phase;
        int            len;
        int            base;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes under the reset settings (raw sum out)
        send_word('0, '0, 1'b0, 1'b1);
        send_word('1, '1, 1'b1, 1'b1);
        send_word('1, '0, 1'b1, 1'b1);
        send_word('0, '1, 1'b0, 1'b0);
        send_word('1, '1, 1'b0, 1'b1);
        send_word(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0);
        send_word(32'h5555_5555, 32'h5555_5555, 1'b0, 1'b1);
        settle_block();

        // sums on and next to each threshold, both directions
        cfg        = '0;
        cfg.enable = 1'b1;
        cfg.low    = -16'sd1;
        cfg.mid    = 16'sd0;
        cfg.high   = 16'sd1;
        cfg.mode   = xpc_pkg::MODE_INC;
        load_config(cfg);
        for (int t = -2; t <= 2; t++)
            send_term(t);
        settle_block();
        cfg.mode = xpc_pkg::MODE_DEC;
        load_config(cfg);
        for (int t = -2; t <= 2; t++)
            send_term(t);
        settle_block();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase

            base       = int'($urandom_range(0, 300)) - 150;
            cfg.enable = 1'b1;
            cfg.low    = xpc_pkg::THR_W'(base);
            cfg.mid    = xpc_pkg::THR_W'(base + int'($urandom_range(0, 60)));
            cfg.high   = xpc_pkg::THR_W'(int'(cfg.mid) + int'($urandom_range(0, 60)));
            cfg.mode   = xpc_pkg::MODE_INC;
            cfg.level  = 2'($urandom_range(0, 3));
            case (p)
                0: begin cfg.enable = 1'b0; cfg.mode = 2'($urandom_range(0, 3)); end
                1: ;
                2: cfg.mode = xpc_pkg::MODE_DEC;
                3: begin cfg.mode = MODE_CONST; cfg.level = 2'd3; end
                4: begin cfg.mode = MODE_SPARE; cfg.level = 2'd0; end
                5:
                begin
                    cfg.low  = 16'h8000;
                    cfg.mid  = 16'h0000;
                    cfg.high = 16'h7FFF;
                end
                6:
                begin
                    // out of order on purpose
                    cfg.mode = xpc_pkg::MODE_DEC;
                    cfg.low  = 16'h7FFF;
                    cfg.mid  = 16'h8000;
                    cfg.high = 16'h0000;
                end
                7:
                begin
                    cfg.high = xpc_pkg::THR_W'(base);
                    cfg.mid  = xpc_pkg::THR_W'(base + int'($urandom_range(0, 60)));
                    cfg.low  = xpc_pkg::THR_W'(int'(cfg.mid) + int'($urandom_range(0, 60)));
                end
                8:
                begin
                    cfg.mode = xpc_pkg::MODE_DEC;
                    cfg.mid  = cfg.low;
                    cfg.high = cfg.low;
                end
                default:
                begin
                    cfg.enable = 1'($urandom_range(0, 1));
                    cfg.mode   = 2'($urandom_range(0, 3));
                    cfg.mid    = xpc_pkg::THR_W'(int'($urandom_range(0, 300)) - 150);
                    cfg.high   = xpc_pkg::THR_W'(int'($urandom_range(0, 300)) - 150);
                end
            endcase
            load_config(cfg);

            // output held off while items keep coming, so the input backs up
            if (p == 2)
                long_hold_req = 1'b1;

            words_in_phase = 0;
            while (words_in_phase < PHASE_WORDS)
            begin
                len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(13, 64))
                                                  : int'($urandom_range(1, 12));
                send_patch(len);
                words_in_phase += len;
            end
            settle_block();
        end

        // one long patch of maximum terms, past the signed 16-bit range but inside the 18-bit sum
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cfg            = '0;
        load_config(cfg);
        for (int i = 0; i < LONG_WORDS; i++)
            send_word('1, '1, 1'b1, i == LONG_WORDS - 1);
        settle_block();

        @(negedge clk);
        $display("Covered %0d words in %0d patches over %0d register settings,",
                 words_sent, patches_sent, configs_loaded);
        $display("with a %0d-word patch of largest terms and a %0d-cycle output hold-off",
                 LONG_WORDS, LONG_HOLD);
        if (fail_count == 0 && results_due == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
